@@ design/mcct_pkg.sv @@
// Shared types and constants for the multi-channel compare timer.
`timescale 1ns / 1ps
`default_nettype none

package mcct_pkg;

  localparam int CHANNELS_DEF     = 4;
  localparam int COUNTER_BITS_DEF = 32;

  localparam int OPCODE_W   = 2;
  localparam int CHANNEL_W  = 2;
  localparam int INTERVAL_W = 32;
  localparam int MASK_W     = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  // Per-channel commands for the cycle in which a request is processed.
  typedef struct packed {
    logic tick;
    logic start;
    logic stop;
    logic periodic;
  } chan_ctrl_t;

endpackage

`default_nettype wire

@@ design/multi_channel_compare_timer_top.sv @@
// Top level of the multi-channel compare timer: request register, counter, result register.
// Flow: a taken request is held in the request register, and its result is presented from the result register.
// Throughput: one request per cycle while the output is not stalled; all channels compare and reload in parallel
//   between the request register and the result register.
// Reset: counter and all active flags clear; compare and reload values are loaded
//   by a start before they are ever used.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_compare_timer_top
  import mcct_pkg::*;
#(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [OPCODE_W-1:0]   opcode_i,
  input  wire logic [CHANNEL_W-1:0]  channel_i,
  input  wire logic                  periodic_i,
  input  wire logic [INTERVAL_W-1:0] interval_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [MASK_W-1:0]          fired_mask_o,
  output logic [MASK_W-1:0]          active_mask_o
);

  localparam int PadW = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;

  // request register
  logic                  req_valid_q;
  logic [OPCODE_W-1:0]   opcode_q;
  logic [CHANNEL_W-1:0]  channel_q;
  logic                  periodic_q;
  logic [INTERVAL_W-1:0] interval_q;

  logic                    advance;
  logic                    go;
  logic                    tick_en, start_en, stop_en;
  logic [COUNTER_BITS-1:0] count_q, count_d, count_next;
  logic [CHANNELS-1:0]     running, running_d, fired;

  logic              out_valid_q;
  logic [MASK_W-1:0] fired_mask_q, active_mask_q;
  logic [PadW-1:0]   fired_pad, running_pad;

  assign advance    = !out_valid_q || !out_stall_i;
  assign go         = req_valid_q && advance;
  assign in_stall_o = req_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      opcode_q   <= opcode_i;
      channel_q  <= channel_i;
      periodic_q <= periodic_i;
      interval_q <= interval_i;
    end
  end

  always_comb begin
    tick_en  = 1'b0;
    start_en = 1'b0;
    stop_en  = 1'b0;
    unique case (op_e'(opcode_q))
      OP_TICK:  tick_en  = go && (|running);
      OP_START: start_en = go;
      OP_STOP:  stop_en  = go;
      default:  ;
    endcase
  end

  assign count_next = count_q + COUNTER_BITS'(1);
  assign count_d    = tick_en ? count_next : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar k = 0; k < CHANNELS; k++) begin : g_chan
    logic       sel;
    chan_ctrl_t ctrl;
    assign sel = (32'(channel_q) == k);

    always_comb begin
      ctrl.tick     = tick_en;
      ctrl.start    = start_en && sel;
      ctrl.stop     = stop_en && sel;
      ctrl.periodic = periodic_q;
    end

    mcct_chan #(
      .COUNTER_BITS(COUNTER_BITS)
    ) u_chan (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .interval_i  (interval_q[COUNTER_BITS-1:0]),
      .count_i     (count_q),
      .count_next_i(count_next),
      .active_o    (running[k]),
      .active_d_o  (running_d[k]),
      .fired_o     (fired[k])
    );
  end

  // drop or pad channel bits to the fixed mask width
  assign fired_pad   = PadW'(fired);
  assign running_pad = PadW'(running_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      fired_mask_q  <= fired_pad[MASK_W-1:0];
      active_mask_q <= running_pad[MASK_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fired_mask_o  = fired_mask_q;
  assign active_mask_o = active_mask_q;

  a_no_fire_off_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && (opcode_q != OP_TICK)) |=> (fired_mask_o == '0))
    else $error("fired mask set by a request that is not a tick");

  a_idle_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && (opcode_q == OP_TICK) && (running == '0)) |=> $stable(count_q))
    else $error("counter moved with no channel active");

  a_stall_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (req_valid_q && out_valid_q))
    else $error("input stalled without a held request and result");

  a_fired_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |-> ((fired & ~running) == '0))
    else $error("inactive channel fired");

endmodule

`default_nettype wire

@@ design/mcct_chan.sv @@
// One timer channel: compare value, reload period, mode flag and active flag.
`timescale 1ns / 1ps
`default_nettype none

module mcct_chan
  import mcct_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire chan_ctrl_t              ctrl_i,
  input  wire logic [COUNTER_BITS-1:0] interval_i,
  input  wire logic [COUNTER_BITS-1:0] count_i,
  input  wire logic [COUNTER_BITS-1:0] count_next_i,
  output logic                         active_o,
  output logic                         active_d_o,
  output logic                         fired_o
);

  logic [COUNTER_BITS-1:0] compare_q, compare_d;
  logic [COUNTER_BITS-1:0] reload_q, reload_d;
  logic                    repeat_q, repeat_d;
  logic                    active_q, active_d;
  logic                    hit;

  assign hit = ctrl_i.tick && active_q && (compare_q == count_next_i);

  always_comb begin
    compare_d = compare_q;
    reload_d  = reload_q;
    repeat_d  = repeat_q;
    active_d  = active_q;
    if (ctrl_i.start) begin
      compare_d = count_i + interval_i;
      reload_d  = interval_i;
      repeat_d  = ctrl_i.periodic;
      active_d  = 1'b1;
    end else if (ctrl_i.stop) begin
      repeat_d = 1'b0;
      active_d = 1'b0;
    end else if (hit) begin
      // periodic: advance to the next expiry; one-shot: drop out
      if (repeat_q) begin
        compare_d = compare_q + reload_q;
      end else begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  // Compare, reload and mode are only looked at while the channel is active.
  always_ff @(posedge clk_i) begin
    compare_q <= compare_d;
    reload_q  <= reload_d;
    repeat_q  <= repeat_d;
  end

  assign active_o   = active_q;
  assign active_d_o = active_d;
  assign fired_o    = hit;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the multi-channel compare timer with its own timer predictor.
`timescale 1ns / 1ps

module tb_top;
  import mcct_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLDOFF_CYCLES = 300;

  // Spare opcode that the block must ignore
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [MASK_W-1:0] fired;
    logic [MASK_W-1:0] active;
  } timer_masks_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [OPCODE_W-1:0]   opcode_i;
  logic [CHANNEL_W-1:0]  channel_i;
  logic                  periodic_i;
  logic [INTERVAL_W-1:0] interval_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [MASK_W-1:0]     fired_mask_o;
  logic [MASK_W-1:0]     active_mask_o;

  // Timer state as the predictor sees it
  logic [COUNTER_BITS_DEF-1:0] us_count;
  logic [COUNTER_BITS_DEF-1:0] chan_compare [CHANNELS_DEF];
  logic [COUNTER_BITS_DEF-1:0] chan_period  [CHANNELS_DEF];
  logic [CHANNELS_DEF-1:0]     chan_periodic;
  logic [CHANNELS_DEF-1:0]     chan_running;

  timer_masks_t pending_masks[$];
  int           error_count;
  bit           calm;
  int           holdoff_req;

  multi_channel_compare_timer_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .channel_i    (channel_i),
    .periodic_i   (periodic_i),
    .interval_i   (interval_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .fired_mask_o (fired_mask_o),
    .active_mask_o(active_mask_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic timer_masks_t predict_timer(input logic [OPCODE_W-1:0] op,
                                                 input logic [CHANNEL_W-1:0] ch,
                                                 input logic per,
                                                 input logic [INTERVAL_W-1:0] ivl);
    timer_masks_t                res;
    logic [COUNTER_BITS_DEF-1:0] span;
    res  = '0;
    span = ivl[COUNTER_BITS_DEF-1:0];
    case (op)
      OP_TICK: begin
        // Counter holds while every channel is idle
        if (chan_running != '0) begin
          us_count = us_count + 1'b1;
          for (int k = 0; k < CHANNELS_DEF; k++) begin
            if (chan_running[k] && chan_compare[k] == us_count) begin
              res.fired[k] = 1'b1;
              if (chan_periodic[k]) chan_compare[k] = chan_compare[k] + chan_period[k];
              else chan_running[k] = 1'b0;
            end
          end
        end
      end
      OP_START: begin
        if (ch < CHANNELS_DEF) begin
          chan_periodic[ch] = per;
          chan_period[ch]   = span;
          chan_compare[ch]  = us_count + span;
          chan_running[ch]  = 1'b1;
        end
      end
      OP_STOP: begin
        if (ch < CHANNELS_DEF) begin
          chan_periodic[ch] = 1'b0;
          chan_running[ch]  = 1'b0;
        end
      end
      default: ;
    endcase
    res.active = chan_running[MASK_W-1:0];
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Offer one request, hold it until taken, then log what it should produce
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [CHANNEL_W-1:0] ch,
                              input logic per, input logic [INTERVAL_W-1:0] ivl);
    bit taken;
    if (!calm) begin
      while ($urandom_range(99) < 6) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    channel_i  <= ch;
    periodic_i <= per;
    interval_i <= ivl;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    pending_masks.push_back(predict_timer(op, ch, per, ivl));
  endtask

  // Pause the sender until every result is back, then set the next traffic mode
  task automatic settle(input bit calm_mode, input int holdoff);
    in_valid_i <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    calm        = calm_mode;
    holdoff_req = holdoff;
    @(posedge clk_i);
  endtask

  task automatic send_random_requests(input int count);
    int                    sel;
    logic [OPCODE_W-1:0]   op;
    logic [INTERVAL_W-1:0] ivl;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 55) op = OP_TICK;
      else if (sel < 80) op = OP_START;
      else if (sel < 97) op = OP_STOP;
      else op = OP_UNUSED;
      // Mostly short intervals so channels actually expire
      sel = $urandom_range(99);
      if (sel < 70) ivl = $urandom_range(12);
      else if (sel < 85) ivl = $urandom_range(200);
      else ivl = $urandom();
      send_request(op, CHANNEL_W'($urandom_range(3)), 1'($urandom_range(1)), ivl);
    end
  endtask

  task automatic test_directed();
    send_request(OP_TICK, 2'd0, 1'b0, 32'd0);
    send_request(OP_UNUSED, 2'd1, 1'b1, 32'd5);
    send_request(OP_STOP, 2'd3, 1'b0, 32'd0);
    // One-shot expiry after three ticks
    send_request(OP_START, 2'd0, 1'b0, 32'd3);
    repeat (3) send_request(OP_TICK, 2'd0, 1'b0, 32'd0);
    send_request(OP_START, 2'd1, 1'b1, 32'd2);
    send_request(OP_START, 2'd2, 1'b0, 32'd0);
    send_request(OP_START, 2'd3, 1'b1, 32'hFFFF_FFFF);
    repeat (4) send_request(OP_TICK, 2'd0, 1'b0, 32'd0);
    // Restart a running channel with new settings
    send_request(OP_START, 2'd1, 1'b0, 32'd1);
    send_request(OP_TICK, 2'd0, 1'b0, 32'd0);
    send_request(OP_START, 2'd0, 1'b1, 32'd1);
    repeat (2) send_request(OP_TICK, 2'd3, 1'b1, 32'hFFFF_FFFF);
    send_request(OP_STOP, 2'd0, 1'b1, 32'hFFFF_FFFF);
    send_request(OP_STOP, 2'd3, 1'b0, 32'd0);
    send_request(OP_STOP, 2'd2, 1'b0, 32'd0);
    send_request(OP_TICK, 2'd0, 1'b0, 32'd0);
  endtask

  task automatic test_random_traffic();
    settle(1'b0, 0);
    send_random_requests(150);
  endtask

  task automatic test_unbroken_stream();
    settle(1'b1, 0);
    send_random_requests(100);
  endtask

  task automatic test_output_backpressure();
    settle(1'b0, HOLDOFF_CYCLES);
    send_random_requests(60);
  endtask

  task automatic test_after_pause();
    settle(1'b0, 0);
    send_random_requests(100);
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off
  initial begin
    int holdoff_left;
    holdoff_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req > 0) begin
        holdoff_left = holdoff_req;
        holdoff_req  = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 6);
      end
    end
  end

  // Compare each result just before the edge that takes it
  initial begin
    timer_masks_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_masks.size() == 0) begin
          report_error($sformatf("result with none pending: fired %h active %h",
                                 fired_mask_o, active_mask_o));
        end else begin
          want = pending_masks.pop_front();
          if (fired_mask_o !== want.fired)
            report_error($sformatf("fired_mask %h, expected %h", fired_mask_o, want.fired));
          if (active_mask_o !== want.active)
            report_error($sformatf("active_mask %h, expected %h", active_mask_o, want.active));
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    error_count   = 0;
    calm          = 1'b0;
    holdoff_req   = 0;
    us_count      = '0;
    chan_periodic = '0;
    chan_running  = '0;
    for (int k = 0; k < CHANNELS_DEF; k++) begin
      chan_compare[k] = '0;
      chan_period[k]  = '0;
    end
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    opcode_i   <= OP_TICK;
    channel_i  <= '0;
    periodic_i <= 1'b0;
    interval_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic();
    test_unbroken_stream();
    test_output_backpressure();
    test_after_pause();

    in_valid_i <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_masks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
